[src/aging_priority_queue_defines.svh]
// assertion helpers used by the checker in src/apq_checker.sv
`ifndef AGING_PRIORITY_QUEUE_DEFINES_SVH
`define AGING_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define APQ_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define APQ_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/apq_pkg.sv]
package apq_pkg;

	// fixed field widths
	localparam int unsigned ID_W   = 16;
	localparam int unsigned PRIO_W = 8;
	localparam int unsigned OCC_W  = 5;
	localparam int unsigned STAT_W = 2;

	// range limits on inserted entries
	localparam logic [31:0] ID_MAX       = 32'd65535;
	localparam logic [31:0] PRIORITY_MAX = 32'd255;

	// operation codes
	localparam logic OP_INSERT   = 1'b0;
	localparam logic OP_RETRIEVE = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD   = 2'd3;

	typedef struct packed {
		logic              operation;
		logic [ID_W-1:0]   entry_id;
		logic [PRIO_W-1:0] entry_priority;
	} req_t;

	typedef struct packed {
		logic [ID_W-1:0]   removed_id;
		logic [STAT_W-1:0] status;
		logic [OCC_W-1:0]  occupancy;
	} rsp_t;

	// broadcast to every cell
	typedef struct packed {
		logic              ins;
		logic              ret;
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} cell_ctrl_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
		logic              le;
	} cell_link_t;

endpackage

[src/apq_cell.sv]
module apq_cell (
	input  logic                clk,
	input  apq_pkg::cell_ctrl_t ctrl,
	input  logic                occupied,
	input  apq_pkg::cell_link_t left,
	input  apq_pkg::cell_link_t right,
	output apq_pkg::cell_link_t link
);

	logic [apq_pkg::ID_W-1:0]   id_q;
	logic [apq_pkg::PRIO_W-1:0] prio_q;
	logic [apq_pkg::PRIO_W-1:0] right_aged;
	logic                       le;

	// entry stays ahead of the new one when its priority is not larger
	assign le = occupied && (prio_q <= ctrl.prio);

	// aging of the entry moving in from the right, floor of one
	assign right_aged = (right.prio > apq_pkg::PRIO_W'(1)) ?
		right.prio - apq_pkg::PRIO_W'(1) : right.prio;

	// insert: keep, take the new entry, or shift in from the left
	// retrieve: shift in from the right, aged
	always_ff @(posedge clk) begin
		if (ctrl.ins && !le) begin
			if (left.le) begin
				id_q   <= ctrl.id;
				prio_q <= ctrl.prio;
			end else begin
				id_q   <= left.id;
				prio_q <= left.prio;
			end
		end else if (ctrl.ret) begin
			id_q   <= right.id;
			prio_q <= right_aged;
		end
	end

	assign link = '{id: id_q, prio: prio_q, le: le};

endmodule

[src/aging_priority_queue.sv]
// Aging priority queue: holds up to DEPTH entries (id, priority) sorted with the
// lowest priority value at the head; equal priorities keep arrival order. An
// insert (operation 0) places the entry behind all entries of lower or equal
// priority; a retrieve (operation 1) returns the head id and lowers every
// remaining priority by one, never below 1. Each request word yields exactly one
// response word carrying removed_id (0 unless a retrieve succeeded), status
// (0 ok, 1 full, 2 empty, 3 id or priority out of range, checked first) and the
// occupancy after the request, taken modulo 32. The entries live in a row of
// DEPTH cells that compare, shift and age in parallel, so requests may follow
// every cycle while responses are taken. The response appears in an output
// register in the cycle after acceptance; a new request is taken while that
// register is empty or in the cycle its word is taken, so a stalled response
// holds off the request side until it drains. No clearing pass is needed
// after reset.
module aging_priority_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  apq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output apq_pkg::rsp_t rsp
);

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_n;
	logic                rsp_valid_q;
	apq_pkg::rsp_t       rsp_q;
	apq_pkg::rsp_t       rsp_n;
	logic                accept;
	logic                bad;
	logic                full;
	logic                empty;
	apq_pkg::cell_ctrl_t ctrl;
	apq_pkg::cell_link_t link [DEPTH];

	// output register frees the request side whenever it drains
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	// request checks
	assign bad = (32'(req.entry_id) > apq_pkg::ID_MAX) ||
		(req.entry_priority == '0) ||
		(32'(req.entry_priority) > apq_pkg::PRIORITY_MAX);
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// cell commands
	always_comb begin
		ctrl.ins  = accept && (req.operation == apq_pkg::OP_INSERT) && !bad && !full;
		ctrl.ret  = accept && (req.operation == apq_pkg::OP_RETRIEVE) && !empty;
		ctrl.id   = req.entry_id;
		ctrl.prio = req.entry_priority;
	end

	// next count
	always_comb begin
		count_n = count_q;
		if (ctrl.ins) begin
			count_n = count_q + CNT_W'(1);
		end else if (ctrl.ret) begin
			count_n = count_q - CNT_W'(1);
		end
	end

	// response word
	always_comb begin
		rsp_n.removed_id = '0;
		rsp_n.status     = apq_pkg::ST_OK;
		rsp_n.occupancy  = apq_pkg::OCC_W'(count_n);
		if (req.operation == apq_pkg::OP_INSERT) begin
			if (bad) begin
				rsp_n.status = apq_pkg::ST_BAD;
			end else if (full) begin
				rsp_n.status = apq_pkg::ST_FULL;
			end
		end else if (empty) begin
			rsp_n.status = apq_pkg::ST_EMPTY;
		end else begin
			rsp_n.removed_id = link[0].id;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_n;
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// row of cells, head at index 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		apq_pkg::cell_link_t left_in;
		apq_pkg::cell_link_t right_in;
		logic                occupied;

		if (i == 0) begin : g_head
			assign left_in = '{id: '0, prio: '0, le: 1'b1};
		end else begin : g_mid_l
			assign left_in = link[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_in = '{id: '0, prio: '0, le: 1'b0};
		end else begin : g_mid_r
			assign right_in = link[i+1];
		end

		assign occupied = (CNT_W'(i) < count_q);

		apq_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occupied (occupied),
			.left     (left_in),
			.right    (right_in),
			.link     (link[i])
		);
	end

endmodule

[src/apq_checker.sv]
`include "aging_priority_queue_defines.svh"

module apq_checker #(
	parameter int unsigned DEPTH = 16
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input apq_pkg::rsp_t rsp
);

	localparam logic [apq_pkg::OCC_W-1:0] DEPTH_OCC = apq_pkg::OCC_W'(DEPTH);

	logic rsp_stall;
	logic rsp_fail;
	logic rsp_full;
	logic rsp_empty;

	// response word conditions
	assign rsp_stall = rsp_valid && !rsp_ready;
	assign rsp_fail  = rsp_valid && (rsp.status != apq_pkg::ST_OK);
	assign rsp_full  = rsp_valid && (rsp.status == apq_pkg::ST_FULL);
	assign rsp_empty = rsp_valid && (rsp.status == apq_pkg::ST_EMPTY);

	// a stalled response word holds
	`APQ_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")

	// only a served retrieve returns an id
	`APQ_ASSERT_IMP(a_id_zero, rsp_fail, rsp.removed_id == '0, "id on failed request")

	// a full rejection reports a full queue
	`APQ_ASSERT_IMP(a_full_occ, rsp_full, rsp.occupancy == DEPTH_OCC, "full with wrong occupancy")

	// an empty rejection reports an empty queue
	`APQ_ASSERT_IMP(a_empty_occ, rsp_empty, rsp.occupancy == '0, "empty with nonzero occupancy")

	// a new request is taken only when the output register can hold its word
	`APQ_ASSERT_IMP(a_ready, rsp_stall, !req_ready, "request taken while response stalled")

endmodule

bind aging_priority_queue apq_checker #(.DEPTH(DEPTH)) u_apq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

[test/apq_checker.sv]
// watches both channels of the aging priority queue, predicts every response word
// from its own copy of the entries and compares it with what the block returns
module apq_tb_checker #(
	parameter int unsigned DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  apq_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  apq_pkg::rsp_t rsp,
	output int            mismatch_count,
	output int            rsp_outstanding
);

	// predicted queue contents, slot 0 is the head
	logic [apq_pkg::ID_W-1:0]   slot_id   [DEPTH];
	logic [apq_pkg::PRIO_W-1:0] slot_prio [DEPTH];
	int unsigned                held = 0;

	// responses predicted but not yet returned, oldest first
	apq_pkg::rsp_t awaited_rsp [$];
	apq_pkg::rsp_t want;
	int            errors = 0;

	// applies one request to the predicted queue and returns its response word
	function automatic apq_pkg::rsp_t serve_request(apq_pkg::req_t w);
		apq_pkg::rsp_t r;
		int unsigned   pos;
		int unsigned   k;
		r = '0;
		r.status = apq_pkg::ST_OK;
		if (w.operation == apq_pkg::OP_INSERT) begin
			if (32'(w.entry_id) > apq_pkg::ID_MAX || w.entry_priority == '0 ||
			    32'(w.entry_priority) > apq_pkg::PRIORITY_MAX) begin
				r.status = apq_pkg::ST_BAD;
			end else if (held >= DEPTH) begin
				r.status = apq_pkg::ST_FULL;
			end else begin
				// behind every entry of lower or equal priority
				pos = 0;
				while (pos < held && slot_prio[pos] <= w.entry_priority)
					pos++;
				for (k = held; k > pos; k--) begin
					slot_id[k]   = slot_id[k-1];
					slot_prio[k] = slot_prio[k-1];
				end
				slot_id[pos]   = w.entry_id;
				slot_prio[pos] = w.entry_priority;
				held++;
			end
		end else begin
			if (held == 0) begin
				r.status = apq_pkg::ST_EMPTY;
			end else begin
				// pop the head, then age the rest down to a floor of one
				r.removed_id = slot_id[0];
				for (k = 1; k < held; k++) begin
					slot_id[k-1]   = slot_id[k];
					slot_prio[k-1] = slot_prio[k];
				end
				held--;
				for (k = 0; k < held; k++) begin
					if (slot_prio[k] > 1)
						slot_prio[k] = slot_prio[k] - 1'b1;
				end
			end
		end
		r.occupancy = apq_pkg::OCC_W'(held);
		return r;
	endfunction

	// check returned words first, then record the newly accepted request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			awaited_rsp.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_rsp.size() == 0) begin
					errors++;
					$display("%0t unexpected response word: removed_id %h status %0d occupancy %0d",
						$time, rsp.removed_id, rsp.status, rsp.occupancy);
				end else begin
					want = awaited_rsp.pop_front();
					if (rsp.removed_id !== want.removed_id || rsp.status !== want.status ||
					    rsp.occupancy !== want.occupancy) begin
						errors++;
						$display({"%0t response mismatch: expected id %h status %0d occ %0d,",
							" actual id %h status %0d occ %0d"}, $time,
							want.removed_id, want.status, want.occupancy,
							rsp.removed_id, rsp.status, rsp.occupancy);
					end
				end
			end
			if (req_valid && req_ready)
				awaited_rsp.push_back(serve_request(req));
		end
		mismatch_count  <= errors;
		rsp_outstanding <= awaited_rsp.size();
	end

endmodule

[test/tb_top.sv]
// stimulus and verdict for the aging priority queue; checking sits in apq_tb_checker
module tb_top;

	localparam int unsigned DEPTH      = 16;
	localparam int          RAND_WORDS = 600;
	localparam int          IDLE_LIMIT = 2000;
	localparam int          LONG_HOLD  = 300;

	// stimulus mixes
	localparam int MIX_FILL  = 0;
	localparam int MIX_DRAIN = 1;
	localparam int MIX_EVEN  = 2;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          req_valid = 1'b0;
	logic          req_ready;
	apq_pkg::req_t req       = '0;
	logic          rsp_valid;
	logic          rsp_ready = 1'b0;
	apq_pkg::rsp_t rsp;

	int mismatch_count;
	int rsp_outstanding;

	aging_priority_queue #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	apq_tb_checker #(
		.DEPTH(DEPTH)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.req            (req),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.rsp            (rsp),
		.mismatch_count (mismatch_count),
		.rsp_outstanding(rsp_outstanding)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// reset
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic apq_pkg::req_t make_word(logic op, logic [apq_pkg::ID_W-1:0] id,
		logic [apq_pkg::PRIO_W-1:0] prio);
		apq_pkg::req_t w;
		w.operation      = op;
		w.entry_id       = id;
		w.entry_priority = prio;
		return w;
	endfunction

	function automatic int draw_gap(bit steady);
		return steady ? 0 : int'($urandom_range(0, 16));
	endfunction

	// fill, drain or balanced mix; narrow priorities force many ties
	function automatic apq_pkg::req_t random_word(int mix);
		apq_pkg::req_t w;
		int            roll;
		roll = int'($urandom_range(0, 99));
		w.entry_id = apq_pkg::ID_W'($urandom_range(0, 65535));
		case (mix)
			MIX_FILL:  w.operation = (roll < 80) ? apq_pkg::OP_INSERT : apq_pkg::OP_RETRIEVE;
			MIX_DRAIN: w.operation = (roll < 20) ? apq_pkg::OP_INSERT : apq_pkg::OP_RETRIEVE;
			default:   w.operation = (roll < 50) ? apq_pkg::OP_INSERT : apq_pkg::OP_RETRIEVE;
		endcase
		roll = int'($urandom_range(0, 99));
		if (roll < 5)
			w.entry_priority = '0;
		else if (roll < 10)
			w.entry_priority = 8'hff;
		else if (roll < 45)
			w.entry_priority = apq_pkg::PRIO_W'($urandom_range(1, 4));
		else
			w.entry_priority = apq_pkg::PRIO_W'($urandom_range(1, 255));
		return w;
	endfunction

	// present one word and hold it until accepted
	task automatic send_word(apq_pkg::req_t w, int gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= w;
		do @(posedge clk); while (!(req_valid && req_ready));
	endtask

	// wait until every predicted response has come back
	task automatic drain_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (rsp_outstanding != 0) @(posedge clk);
	endtask

	// request side
	initial begin : req_side
		int n;
		int mix;
		bit steady;
		mix    = MIX_EVEN;
		steady = 1'b0;
		while (!arst_n) @(posedge clk);

		// retrieve on empty, with all-ones fields that must be ignored
		send_word(make_word(apq_pkg::OP_RETRIEVE, 16'hffff, 8'hff), draw_gap(steady));
		// priority zero is out of range
		send_word(make_word(apq_pkg::OP_INSERT, 16'h0000, 8'h00), draw_gap(steady));
		send_word(make_word(apq_pkg::OP_INSERT, 16'hffff, 8'hff), draw_gap(steady));
		// equal priorities keep arrival order
		send_word(make_word(apq_pkg::OP_INSERT, 16'h0001, 8'h01), draw_gap(steady));
		send_word(make_word(apq_pkg::OP_INSERT, 16'h0002, 8'h01), draw_gap(steady));
		// fill to capacity
		for (n = 3; n < DEPTH; n++)
			send_word(make_word(apq_pkg::OP_INSERT, apq_pkg::ID_W'($urandom_range(0, 65535)),
				apq_pkg::PRIO_W'($urandom_range(1, 255))), draw_gap(steady));
		// full, then bad priority while full: range check comes first
		send_word(make_word(apq_pkg::OP_INSERT, 16'h1234, 8'h05), draw_gap(steady));
		send_word(make_word(apq_pkg::OP_INSERT, 16'h4321, 8'h00), draw_gap(steady));
		// retrieves age the survivors toward the floor
		for (n = 0; n < 5; n++)
			send_word(make_word(apq_pkg::OP_RETRIEVE, apq_pkg::ID_W'($urandom_range(0, 65535)),
				apq_pkg::PRIO_W'($urandom_range(0, 255))), draw_gap(steady));

		for (n = 0; n < RAND_WORDS; n++) begin
			if (n % 50 == 0)
				steady = ($urandom_range(0, 3) == 0);
			if (n % 40 == 0)
				mix = int'($urandom_range(MIX_FILL, MIX_EVEN));
			if (n == RAND_WORDS * 2 / 3)
				drain_responses();
			send_word(random_word(mix), draw_gap(steady));
		end

		drain_responses();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && rsp_outstanding == 0) begin
			$display("aging_priority_queue verification clean");
		end else begin
			$display("aging_priority_queue verification failed");
		end
		$finish;
	end

	// response side, with one long hold-off so the block backs up
	initial begin : rsp_side
		int  stall;
		int  taken;
		bit  steady;
		taken  = 0;
		steady = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (taken % 50 == 0)
				steady = ($urandom_range(0, 3) == 0);
			stall = draw_gap(steady);
			if (taken == 200)
				stall = LONG_HOLD;
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
			taken++;
		end
	end

	// watchdog on cycles with no word moving on either channel
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("aging_priority_queue verification failed");
				$finish;
			end
		end
	end

endmodule

[filelist.f]
+incdir+src
src/apq_pkg.sv
src/apq_cell.sv
src/aging_priority_queue.sv
src/apq_checker.sv
test/apq_checker.sv
test/tb_top.sv
